>>> rtl/gcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_pkg: shared types, constants and pattern helpers
// Window geometry, result codes and the character compare functions used by
// the Greek CH matcher.
// ----------------------------------------------------------------------------
package gcm_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  // Window covers offsets -5 .. +8 around the C of CH
  localparam int WIN_BEFORE = 5;
  localparam int WIN_CHARS  = 14;
  localparam int WIN_W      = 8 * WIN_CHARS;
  localparam int HEAD_CHARS = 7;
  localparam int PAT_CHARS  = 10;
  localparam int PAT_W      = 8 * PAT_CHARS;

  localparam logic [7:0] CODE_K    = 8'd75;
  localparam logic [7:0] CODE_X    = 8'd88;
  localparam logic [7:0] CODE_NONE = 8'd0;

  typedef logic [WIN_W-1:0] win_t;

  typedef struct packed {
    logic       is_greek;
    logic [7:0] primary_code;
    logic [7:0] alternate_code;
    logic [5:0] next_pos;
  } result_t;

  // Compare len characters of chars (char 0 in the low byte) starting at base
  // against a string literal, which is right-aligned in pat.
  function automatic logic chars_eq(input win_t chars, input int base,
                                    input logic [PAT_W-1:0] pat, input int len);
    logic r;
    r = 1'b1;
    for (int k = 0; k < PAT_CHARS; k++) begin
      if (k < len) begin
        if (chars[8*(base+k) +: 8] != pat[8*(len-1-k) +: 8]) begin
          r = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Pattern at pos+off, must lie fully inside [0, wl)
  function automatic logic seq_win(input win_t win, input logic [4:0] pos,
                                   input logic [5:0] wl, input int off,
                                   input logic [PAT_W-1:0] pat, input int len);
    int p;
    p = int'(pos) + off;
    return (p >= 0) && (p + len <= int'(wl)) &&
           chars_eq(win, off + WIN_BEFORE, pat, len);
  endfunction

  // Pattern at position zero
  function automatic logic seq_head(input win_t head, input logic [5:0] wl,
                                    input logic [PAT_W-1:0] pat, input int len);
    return (len <= int'(wl)) && chars_eq(head, 0, pat, len);
  endfunction

endpackage

>>> rtl/gcm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_store: word character store with window shifter
// Holds the characters of one word and presents the 14-character window
// around the evaluated position plus the first characters of the word.
// ----------------------------------------------------------------------------
module gcm_store #(
  parameter int MAX_WORD = 32
) (
  input  logic                clk,
  input  logic                we,
  input  logic [4:0]          waddr,
  input  logic [7:0]          wdata,
  input  logic [4:0]          pos,
  output gcm_pkg::win_t       win,
  output gcm_pkg::win_t       head
);
  import gcm_pkg::*;

  localparam int AW    = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int PRE_W = 8 * WIN_BEFORE;
  localparam int EXT_W = WIN_W + 8 * MAX_WORD + PRE_W;

  logic [7:0]            mem [MAX_WORD];
  logic [8*MAX_WORD-1:0] flat;
  logic [EXT_W-1:0]      ext;
  logic [EXT_W-1:0]      shifted;

  always_ff @(posedge clk) begin
    if (we && int'(waddr) < MAX_WORD) begin
      mem[AW'(waddr)] <= wdata;
    end
  end

  for (genvar i = 0; i < MAX_WORD; i++) begin : g_flat
    assign flat[8*i +: 8] = mem[i];
  end

  // Leading zero chars let negative offsets fall out of the shift naturally
  assign ext     = {{WIN_W{1'b0}}, flat, {PRE_W{1'b0}}};
  assign shifted = ext >> {pos, 3'b000};
  assign win     = shifted[WIN_W-1:0];
  assign head    = {{(WIN_W - 8*HEAD_CHARS){1'b0}}, flat[8*HEAD_CHARS-1:0]};

endmodule

>>> rtl/gcm_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_match: Greek CH pattern decision
// Compares the character window against the fixed pattern set, with the
// exclusions, the word-start prefixes and the word-final vowel case.
// ----------------------------------------------------------------------------
module gcm_match #(
  parameter int MAX_WORD = 32
) (
  input  gcm_pkg::win_t    win,
  input  gcm_pkg::win_t    head,
  input  logic [4:0]       pos,
  input  logic [5:0]       word_len,
  output gcm_pkg::result_t res
);
  import gcm_pkg::*;

  logic [5:0] wl;
  logic       hit;
  logic       g_a6, g_a5, g_tr, g_a4, g_b5, g_c5, g_b6, g_b4, g_orc, g_a8;
  logic       g_d5, g_c6, g_a7, g_b8, g_a9, g_a10, g_pre, g_end;

  assign wl = (int'(word_len) > MAX_WORD) ? 6'(MAX_WORD) : word_len;

  function automatic logic at(input int off, input logic [PAT_W-1:0] pat,
                              input int len);
    return seq_win(win, pos, wl, off, pat, len);
  endfunction

  always_comb begin
    g_a6 = at(-2, "ORCHID", 6) || at(-2, "NICHOL", 6) || at(-2, "MECHAN", 6) ||
           at(-2, "LICHEN", 6) || at(-2, "MACHIC", 6) || at(-2, "PACHEL", 6) ||
           at(-2, "RACHIF", 6) || at(-2, "RACHID", 6) || at(-2, "RACHIS", 6) ||
           at(-2, "RACHIC", 6) || at(-2, "MICHAL", 6);
    g_a5 = at(-3, "MELCH", 5) || at(-3, "GLOCH", 5) || at(-3, "TRACH", 5) ||
           at(-3, "TROCH", 5) || at(-3, "BRACH", 5) || at(-3, "SYNCH", 5) ||
           at(-3, "PSYCH", 5) || at(-3, "STICH", 5) || at(-3, "PULCH", 5) ||
           at(-3, "EPOCH", 5);
    g_tr = at(-3, "TRICH", 5) && !at(-5, "OSTRICH", 7);
    g_a4 = (at(-2, "TYCH", 4) || at(-2, "TOCH", 4) || at(-2, "BUCH", 4) ||
            at(-2, "MOCH", 4) || at(-2, "CICH", 4) || at(-2, "DICH", 4) ||
            at(-2, "NUCH", 4) || at(-2, "EICH", 4) || at(-2, "LOCH", 4) ||
            at(-2, "DOCH", 4) || at(-2, "ZECH", 4) || at(-2, "WYCH", 4)) &&
           !at(-4, "INDOCHINA", 9) && !at(-2, "BUCHON", 6);
    g_b5 = at(-2, "LYCHN", 5) || at(-2, "TACHO", 5) || at(-2, "ORCHO", 5) ||
           at(-2, "ORCHI", 5) || at(-2, "LICHO", 5);
    g_c5 = (pos == 5'd1 || pos == 5'd2) &&
           (at(-1, "OCHER", 5) || at(-1, "ECHIN", 5) || at(-1, "ECHID", 5));
    g_b6 = at(-4, "BRONCH", 6) || at(-4, "STOICH", 6) || at(-4, "STRYCH", 6) ||
           at(-4, "TELECH", 6) || at(-4, "PLANCH", 6) || at(-4, "CATECH", 6) ||
           at(-4, "MANICH", 6) || at(-4, "MALACH", 6) || at(-4, "BIANCH", 6) ||
           at(-4, "DIDACH", 6);
    g_b4 = (pos == 5'd1) && (at(-1, "ICHA", 4) || at(-1, "ICHN", 4));
    g_orc = at(-2, "ORCHESTR", 8);
    g_a8 = at(-4, "BRANCHIO", 8) || at(-4, "BRANCHIF", 8);
    g_d5 = (at(-1, "ACHAB", 5) || at(-1, "ACHAD", 5) || at(-1, "ACHAN", 5) ||
            at(-1, "ACHAZ", 5)) &&
           !(at(-2, "MACHADO", 7) || at(-2, "LACHANC", 7));
    g_c6 = at(-1, "ACHISH", 6) || at(-1, "ACHILL", 6) || at(-1, "ACHAIA", 6) ||
           at(-1, "ACHENE", 6);
    g_a7 = at(-1, "ACHAIAN", 7) || at(-1, "ACHATES", 7) ||
           at(-1, "ACHIRAL", 7) || at(-1, "ACHERON", 7);
    g_b8 = at(-1, "ACHILLEA", 8) || at(-1, "ACHIMAAS", 8) ||
           at(-1, "ACHILARY", 8) || at(-1, "ACHELOUS", 8) ||
           at(-1, "ACHENIAL", 8) || at(-1, "ACHERNAR", 8);
    g_a9 = at(-1, "ACHALASIA", 9) || at(-1, "ACHILLEAN", 9) ||
           at(-1, "ACHIMENES", 9);
    g_a10 = at(-1, "ACHIMELECH", 10) || at(-1, "ACHITOPHEL", 10);
    g_pre = (pos == 5'd2) &&
            (seq_head(head, wl, "INCHOA", 6) || seq_head(head, wl, "ISCH", 4));
    // CH closing the word after a vowel
    g_end = (int'(pos) + 2 == int'(wl)) && (pos != 5'd0) &&
            (at(-1, "A", 1) || at(-1, "O", 1) || at(-1, "U", 1) ||
             at(-1, "E", 1)) &&
            !(seq_head(head, wl, "DEBAUCH", 7) ||
              at(-2, "MUCH", 4) || at(-2, "SUCH", 4) || at(-2, "KOCH", 4) ||
              at(-5, "OODRICH", 7) || at(-5, "ALDRICH", 7));

    hit = g_a6 || g_a5 || g_tr || g_a4 || g_b5 || g_c5 || g_b6 || g_b4 ||
          g_orc || g_a8 || g_d5 || g_c6 || g_a7 || g_b8 || g_a9 || g_a10 ||
          g_pre || g_end;

    res.is_greek       = hit;
    res.primary_code   = hit ? CODE_K : CODE_NONE;
    res.alternate_code = hit ? CODE_X : CODE_NONE;
    res.next_pos       = hit ? ({1'b0, pos} + 6'd2) : {1'b0, pos};
  end

endmodule

>>> rtl/greek_ch_context_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greek_ch_context_matcher_core: Greek CH context matcher
// Stores a word and decides whether the CH at a given position is Greek.
// ----------------------------------------------------------------------------
// Usage: send write items (opcode 0) to load the word characters, then an
// evaluate item (opcode 1) with the position of the C and the word length.
// One item is accepted per cycle while in_stall is low. A write lands in the
// store at acceptance and yields no result; an evaluate yields one result,
// held by the input register and the result register around the window
// shifter and pattern compare. Only characters written beforehand may
// be covered by an evaluation; unwritten store entries read as garbage.
// ----------------------------------------------------------------------------
module greek_ch_context_matcher_core #(
  parameter int MAX_WORD = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [4:0] char_index,
  input  logic [7:0] char_code,
  input  logic [4:0] current_pos,
  input  logic [5:0] word_length,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_greek,
  output logic [7:0] primary_code,
  output logic [7:0] alternate_code,
  output logic [5:0] next_pos
);
  import gcm_pkg::*;

  logic       out_free;
  logic       in_take;
  logic       is_eval;
  logic       s1_valid;
  logic [4:0] s1_pos;
  logic [5:0] s1_len;
  win_t       win;
  win_t       head;
  result_t    match_res;
  result_t    res;

  assign is_eval  = (opcode == OP_EVAL);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  gcm_store #(.MAX_WORD(MAX_WORD)) u_store (
    .clk   (clk),
    .we    (in_take && !is_eval),
    .waddr (char_index),
    .wdata (char_code),
    .pos   (s1_pos),
    .win   (win),
    .head  (head)
  );

  gcm_match #(.MAX_WORD(MAX_WORD)) u_match (
    .win      (win),
    .head     (head),
    .pos      (s1_pos),
    .word_len (s1_len),
    .res      (match_res)
  );

  // Input register: evaluate items only
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_take && is_eval;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && is_eval) begin
      s1_pos <= current_pos;
      s1_len <= word_length;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      res <= match_res;
    end
  end

  assign is_greek       = res.is_greek;
  assign primary_code   = res.primary_code;
  assign alternate_code = res.alternate_code;
  assign next_pos       = res.next_pos;

endmodule

>>> rtl/gcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_checker: port-level checks for the Greek CH matcher
// Watches the top-level ports and flags inconsistent results or stalls.
// ----------------------------------------------------------------------------
module gcm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       is_greek,
  input logic [7:0] primary_code,
  input logic [7:0] alternate_code,
  input logic [5:0] next_pos
);
  import gcm_pkg::*;

  // A held result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Input only backs up behind a stalled full output
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_hit_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_greek |-> primary_code == CODE_K && alternate_code == CODE_X)
    else $error("match codes wrong");

  a_miss_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_greek |-> primary_code == CODE_NONE &&
                               alternate_code == CODE_NONE)
    else $error("codes set without a match");

  a_hit_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_greek |-> next_pos >= 6'd2)
    else $error("next position not advanced on match");

endmodule

bind greek_ch_context_matcher_core gcm_checker u_gcm_checker (.*);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for greek_ch_context_matcher_core
// Loads words into the character store, asks for Greek CH decisions at the
// CH positions and elsewhere, and checks every decision against a behavioral
// predictor of the pattern set. Both handshake sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import gcm_pkg::*;

  localparam int STORE_DEPTH = 32;
  localparam int ITEM_TARGET = 900;
  localparam int TAIL_ITEMS  = 100;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    op_t        op;
    logic [4:0] idx;
    logic [7:0] code;
    logic [4:0] pos;
    logic [5:0] wl;
  } greek_cmd_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       opcode = 1'b0;
  logic [4:0] char_index = '0;
  logic [7:0] char_code = '0;
  logic [4:0] current_pos = '0;
  logic [5:0] word_length = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       is_greek;
  logic [7:0] primary_code;
  logic [7:0] alternate_code;
  logic [5:0] next_pos;

  greek_cmd_t pending[$];
  result_t    greek_due[$];
  logic [7:0] word_mem [STORE_DEPTH];
  int         eff_len;
  bit [31:0]  filled = '0;
  int         total_items = 1 << 30;
  int         taken_cnt;
  int         err_cnt;
  int         cyc_cnt;
  logic       in_taken;
  logic       tail_run;
  greek_cmd_t cmd;
  int         send_gap, send_mode_left;
  bit         send_bursty;
  int         stall_left, stall_mode_left;
  bit         stall_bursty;
  string      letters = "ACEHIORSTNUMLBDYKGP";

  greek_ch_context_matcher_core #(.MAX_WORD(STORE_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .char_index(char_index), .char_code(char_code),
    .current_pos(current_pos), .word_length(word_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_greek(is_greek), .primary_code(primary_code),
    .alternate_code(alternate_code), .next_pos(next_pos)
  );

  always #6 clk = ~clk;

  assign tail_run = (total_items - taken_cnt) < TAIL_ITEMS;

  // ---------------------------------------------------------------- predictor
  // Pattern must lie fully inside [0, eff_len)
  function automatic bit on_word(int pos, string pat);
    int n;
    n = pat.len();
    if (pos < 0 || pos + n > eff_len) return 1'b0;
    for (int i = 0; i < n; i++)
      if (word_mem[pos+i] != pat.getc(i)) return 1'b0;
    return 1'b1;
  endfunction

  // pats is a space separated list
  function automatic bit on_any(int pos, string pats);
    int start;
    start = 0;
    for (int i = 0; i <= pats.len(); i++) begin
      if (i == pats.len() || pats.getc(i) == 8'h20) begin
        if (on_word(pos, pats.substr(start, i - 1))) return 1'b1;
        start = i + 1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit greek_ch_hit(int c);
    int last;
    last = eff_len - 1;
    return on_any(c-2, "ORCHID NICHOL MECHAN LICHEN MACHIC PACHEL RACHIF RACHID RACHIS RACHIC MICHAL")
      || on_any(c-3, "MELCH GLOCH TRACH TROCH BRACH SYNCH PSYCH STICH PULCH EPOCH")
      || (on_word(c-3, "TRICH") && !on_word(c-5, "OSTRICH"))
      || (on_any(c-2, "TYCH TOCH BUCH MOCH CICH DICH NUCH EICH LOCH DOCH ZECH WYCH")
          && !on_word(c-4, "INDOCHINA") && !on_word(c-2, "BUCHON"))
      || on_any(c-2, "LYCHN TACHO ORCHO ORCHI LICHO")
      || ((c == 1 || c == 2) && on_any(c-1, "OCHER ECHIN ECHID"))
      || on_any(c-4, "BRONCH STOICH STRYCH TELECH PLANCH CATECH MANICH MALACH BIANCH DIDACH")
      || (c == 1 && on_any(c-1, "ICHA ICHN"))
      || on_word(c-2, "ORCHESTR")
      || on_any(c-4, "BRANCHIO BRANCHIF")
      || (on_any(c-1, "ACHAB ACHAD ACHAN ACHAZ") && !on_any(c-2, "MACHADO LACHANC"))
      || on_any(c-1, "ACHISH ACHILL ACHAIA ACHENE")
      || on_any(c-1, "ACHAIAN ACHATES ACHIRAL ACHERON")
      || on_any(c-1, "ACHILLEA ACHIMAAS ACHILARY ACHELOUS ACHENIAL ACHERNAR")
      || on_any(c-1, "ACHALASIA ACHILLEAN ACHIMENES")
      || on_any(c-1, "ACHIMELECH ACHITOPHEL")
      || (c == 2 && (on_word(0, "INCHOA") || on_word(0, "ISCH")))
      // CH closing the word after a vowel
      || (c + 1 == last && c >= 1 && on_any(c-1, "A O U E")
          && !(on_word(0, "DEBAUCH") || on_any(c-2, "MUCH SUCH KOCH")
               || on_any(c-5, "OODRICH ALDRICH")));
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic [7:0] rand_letter();
    return letters.getc($urandom_range(0, letters.len() - 1));
  endfunction

  task automatic push_write(input int idx, input logic [7:0] code);
    greek_cmd_t c;
    c.op   = OP_WRITE;
    c.idx  = idx[4:0];
    c.code = code;
    c.pos  = 5'($urandom_range(0, 31));
    c.wl   = 6'($urandom_range(0, 63));
    pending.push_back(c);
    filled[idx] = 1'b1;
  endtask

  // every character inside the word must have been written before it is read
  task automatic push_eval(input int pos, input int wl);
    greek_cmd_t c;
    int span;
    span = (wl > STORE_DEPTH) ? STORE_DEPTH : wl;
    for (int i = 0; i < span; i++)
      if (!filled[i]) push_write(i, rand_letter());
    c.op   = OP_EVAL;
    c.idx  = 5'($urandom_range(0, 31));
    c.code = 8'($urandom_range(0, 255));
    c.pos  = pos[4:0];
    c.wl   = wl[5:0];
    pending.push_back(c);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_write(i, s.getc(i));
  endtask

  initial begin
    string      seeds[$];
    string      seed;
    logic [7:0] wbuf [STORE_DEPTH];
    int         wlen, pre, suf, roll, k, wl;
    bit         rev;

    seeds = '{"ORCHID", "NICHOLAS", "MECHANIC", "LICHEN", "MACHICOLATE", "PACHELBEL",
              "RACHIFORM", "RACHIDIAN", "RACHIS", "RACHIC", "MICHAL", "MELCHIOR",
              "GLOCHID", "TRACHEA", "TROCHEE", "BRACHIAL", "SYNCHRO", "PSYCHE",
              "STICHIC", "PULCHRITUDE", "EPOCH", "TRICHINA", "OSTRICH", "TYCHO",
              "TOCHARIAN", "BUCHNER", "BUCHON", "MOCHA", "CICHLID", "DICHOTOMY",
              "NUCHAL", "EICHLER", "LOCH", "DOCHMIAC", "ZECHARIAH", "WYCHERLY",
              "INDOCHINA", "LYCHNIS", "TACHOMETER", "ORCHOTOMY", "ORCHIL", "LICHO",
              "OCHER", "ECHINUS", "ECHIDNA", "BRONCHIAL", "STOICHIOMETRY",
              "STRYCHNINE", "TELECHIRIC", "PLANCHETTE", "CATECHISM", "MANICHEAN",
              "MALACHITE", "BIANCHI", "DIDACHE", "ICHABOD", "ICHNEUMON", "ORCHESTRA",
              "BRANCHIOPOD", "BRANCHIFORM", "ACHAB", "ACHAD", "MACHADO", "LACHANCE",
              "ACHAN", "ACHAZ", "ACHISH", "ACHILLES", "ACHAIA", "ACHENE", "ACHAIAN",
              "ACHATES", "ACHIRAL", "ACHERON", "ACHILLEA", "ACHIMAAS", "ACHILARY",
              "ACHELOUS", "ACHENIAL", "ACHERNAR", "ACHALASIA", "ACHILLEAN",
              "ACHIMENES", "ACHIMELECH", "ACHITOPHEL", "INCHOATE", "ISCHEMIA", "BACH",
              "EACH", "DEBAUCH", "MUCH", "SUCH", "KOCH", "GOODRICH", "ALDRICH",
              "CHURCH", "CHORUS"};

    // directed: prefix rule, word end cut, zero length, store extremes,
    // vowel-final CH with and without its exclusion
    push_text("ISCH");
    push_eval(2, 4);
    push_eval(2, 3);
    push_eval(0, 0);
    push_eval(31, 4);
    push_write(31, 8'hFF);
    push_write(30, 8'h00);
    push_text("EPOCH");
    push_eval(3, 5);
    push_text("SUCH");
    push_eval(2, 4);
    push_write(1, "A");
    push_eval(2, 4);

    while (pending.size() < ITEM_TARGET) begin
      roll = $urandom_range(0, 9);
      if (roll < 8) begin
        // word built around a seed, mostly well formed
        seed = seeds[$urandom_range(0, seeds.size() - 1)];
        pre  = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
        if ($urandom_range(0, 15) == 0) pre = $urandom_range(0, STORE_DEPTH - seed.len());
        suf  = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
        wlen = 0;
        repeat (pre) begin
          wbuf[wlen] = rand_letter();
          wlen++;
        end
        for (k = 0; k < seed.len() && wlen < STORE_DEPTH; k++) begin
          wbuf[wlen] = seed.getc(k);
          wlen++;
        end
        repeat (suf) if (wlen < STORE_DEPTH) begin
          wbuf[wlen] = rand_letter();
          wlen++;
        end
        if (roll == 7) wbuf[$urandom_range(0, wlen - 1)] = rand_letter();
        rev = $urandom_range(0, 3) == 0;
        for (k = 0; k < wlen; k++)
          push_write(rev ? wlen - 1 - k : k, wbuf[rev ? wlen - 1 - k : k]);
        for (k = 0; k + 1 < wlen; k++) begin
          if (wbuf[k] == "C" && wbuf[k+1] == "H") begin
            wl = wlen;
            case ($urandom_range(0, 9))
              0: wl = (wlen > 3) ? wlen - $urandom_range(1, 3) : wlen;
              1: wl = $urandom_range(33, 63);
              default: wl = wlen;
            endcase
            push_eval(k, wl);
          end
        end
        if ($urandom_range(0, 3) == 0) push_eval($urandom_range(0, wlen - 1), wlen);
      end else begin
        // noise: raw bytes and arbitrary positions and lengths
        repeat ($urandom_range(1, 4))
          push_write($urandom_range(0, 31), 8'($urandom_range(0, 255)));
        case ($urandom_range(0, 5))
          0: wl = 0;
          1: wl = $urandom_range(33, 63);
          2: wl = STORE_DEPTH;
          default: wl = $urandom_range(1, 32);
        endcase
        push_eval($urandom_range(0, 31), wl);
      end
    end
    total_items = pending.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (taken_cnt < total_items) @(negedge clk);
    while (greek_due.size() > 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (greek_due.size() > 0)
      $display("%0t: %0d decisions never arrived", $time, greek_due.size());
    if (err_cnt == 0 && greek_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    taken_cnt       = 0;
    err_cnt         = 0;
    cyc_cnt         = 0;
    eff_len         = 0;
    in_taken        = 1'b0;
    send_gap        = 0;
    send_mode_left  = 0;
    send_bursty     = 1'b0;
    stall_left      = 0;
    stall_mode_left = 0;
    stall_bursty    = 1'b0;
  end

  initial begin
    wait (cyc_cnt >= CYCLE_LIMIT);
    $display("%0t: cycle limit reached", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    if (!rst) begin
      if (send_mode_left == 0) begin
        send_bursty    = $urandom_range(0, 2) != 0;
        send_mode_left = $urandom_range(20, 120);
      end else begin
        send_mode_left--;
      end
      if (in_taken || !in_valid) begin
        if (send_gap > 0 && !tail_run) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          cmd = pending.pop_front();
          in_valid    <= 1'b1;
          opcode      <= cmd.op;
          char_index  <= cmd.idx;
          char_code   <= cmd.code;
          current_pos <= cmd.pos;
          word_length <= cmd.wl;
          if (send_bursty && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_mode_left == 0) begin
        stall_bursty    = $urandom_range(0, 2) != 0;
        stall_mode_left = $urandom_range(20, 120);
      end else begin
        stall_mode_left--;
      end
      if (tail_run) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (stall_bursty && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 19);
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    result_t want;
    bit      hit;
    cyc_cnt <= cyc_cnt + 1;
    if (rst) begin
      in_taken <= 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++) word_mem[i] = 8'h00;
    end else begin
      // check before predicting: a decision never leaves in its own cycle
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (greek_due.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected decision greek=%0d k=%0d x=%0d next=%0d", $time,
                   is_greek, primary_code, alternate_code, next_pos);
        end else begin
          want = greek_due.pop_front();
          if (is_greek !== want.is_greek || primary_code !== want.primary_code ||
              alternate_code !== want.alternate_code || next_pos !== want.next_pos) begin
            err_cnt++;
            $display("%0t: expected greek=%0d k=%0d x=%0d next=%0d, got greek=%0d k=%0d x=%0d next=%0d",
                     $time, want.is_greek, want.primary_code, want.alternate_code,
                     want.next_pos, is_greek, primary_code, alternate_code, next_pos);
          end
        end
      end
      if (in_valid && in_stall === 1'b0) begin
        taken_cnt++;
        if (opcode == OP_WRITE) begin
          word_mem[char_index] = char_code;
        end else begin
          eff_len = (word_length > STORE_DEPTH) ? STORE_DEPTH : int'(word_length);
          hit = greek_ch_hit(int'(current_pos));
          want.is_greek       = hit;
          want.primary_code   = hit ? CODE_K : CODE_NONE;
          want.alternate_code = hit ? CODE_X : CODE_NONE;
          want.next_pos       = hit ? {1'b0, current_pos} + 6'd2 : {1'b0, current_pos};
          greek_due.push_back(want);
        end
      end
      in_taken <= in_valid && in_stall === 1'b0;
    end
  end

endmodule

>>> sim.f
rtl/gcm_pkg.sv
rtl/gcm_store.sv
rtl/gcm_match.sv
rtl/greek_ch_context_matcher_core.sv
rtl/gcm_checker.sv
sim/tb_top.sv
